@@ rtl/sexpr_token_boundary_marker_core_assert.svh @@
// Assertion macros used by the checker of the token boundary marker.
`ifndef SEXPR_TOKEN_BOUNDARY_MARKER_CORE_ASSERT_SVH
`define SEXPR_TOKEN_BOUNDARY_MARKER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define STBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/stbm_pkg.sv @@
// Types and constants for the s-expression token boundary marker.
`default_nettype none
package stbm_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_ATOM    = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4
  } mode_e;

  localparam logic [1:0] ROLE_SKIP  = 2'd0;
  localparam logic [1:0] ROLE_BEGIN = 2'd1;
  localparam logic [1:0] ROLE_CONT  = 2'd2;

  localparam logic [1:0] KIND_OPEN   = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_STRING = 2'd2;
  localparam logic [1:0] KIND_ATOM   = 2'd3;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_OPEN      = 8'h28;
  localparam logic [7:0] CHAR_CLOSE     = 8'h29;
  localparam logic [7:0] CHAR_SEMI      = 8'h3B;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MarkW = 8;

  // Packed so that the first field sits in the highest bit.
  typedef struct packed {
    logic       unterminated_string;
    logic       stream_ended;
    logic       token_closed_here;
    logic [1:0] token_kind;
    logic [1:0] byte_role;
    logic       atom_closed_before;
  } mark_t;

endpackage
`default_nettype wire

@@ rtl/sexpr_token_boundary_marker_core.sv @@
// Top level of the s-expression token boundary marker.
// Each source byte accepted on the input stream yields one mark word on the output
// stream, in order. The block sustains one word per cycle in both directions while the
// output is not stalled. A byte is held in an input register and then classified into a
// result register that drives the output. The rate is set by the single lexer mode
// register, which the classification logic updates once per byte. A zero byte ends a
// stream and returns the lexer to idle, so the following bytes start a new stream.
`default_nettype none
module sexpr_token_boundary_marker_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // in_byte
  input  logic [stbm_pkg::ByteW-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // atom_closed_before, byte_role[1:0], token_kind[1:0], token_closed_here,
  // stream_ended, unterminated_string
  output logic [stbm_pkg::MarkW-1:0]  m_axis_tdata
);
  import stbm_pkg::*;

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  mode_e            mode_q;
  mode_e            mode_d;
  mark_t            mark_d;
  logic             out_vld_q;
  mark_t            mark_q;
  logic             s_fire;
  logic             step_fire;

  assign step_fire     = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  stbm_step u_step (
    .byte_i (in_byte_q),
    .mode_i (mode_q),
    .mode_o (mode_d),
    .mark_o (mark_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_IDLE;
    end else begin
      in_vld_q  <= s_fire || (in_vld_q && !step_fire);
      out_vld_q <= step_fire || (out_vld_q && !m_axis_tready);
      if (step_fire) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step_fire) begin
      mark_q <= mark_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = mark_q;

endmodule
`default_nettype wire

@@ rtl/stbm_step.sv @@
// Per-byte lexer step: classifies one byte against the current mode.
`default_nettype none
module stbm_step (
  input  logic [stbm_pkg::ByteW-1:0] byte_i,
  input  stbm_pkg::mode_e            mode_i,
  output stbm_pkg::mode_e            mode_o,
  output stbm_pkg::mark_t            mark_o
);
  import stbm_pkg::*;

  logic is_nul;
  logic is_blank;
  logic ends_atom;

  assign is_nul    = (byte_i == CHAR_NUL);
  assign is_blank  = (byte_i == CHAR_SPACE) || ((byte_i >= CHAR_TAB) && (byte_i <= CHAR_CR));
  assign ends_atom = is_nul || is_blank || (byte_i == CHAR_OPEN) ||
                     (byte_i == CHAR_CLOSE) || (byte_i == CHAR_SEMI);

  always_comb begin
    logic fresh;
    fresh  = 1'b0;
    mode_o = mode_i;
    mark_o = '0;
    unique case (mode_i)
      MODE_COMMENT: begin
        if (is_nul) begin
          mark_o.stream_ended = 1'b1;
          mode_o = MODE_IDLE;
        end else if (byte_i == CHAR_NEWLINE) begin
          mode_o = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (is_nul) begin
          mark_o.stream_ended        = 1'b1;
          mark_o.unterminated_string = 1'b1;
          mode_o = MODE_IDLE;
        end else begin
          mark_o.byte_role  = ROLE_CONT;
          mark_o.token_kind = KIND_STRING;
          if (byte_i == CHAR_BACKSLASH) begin
            mode_o = MODE_ESCAPE;
          end else if (byte_i == CHAR_QUOTE) begin
            mark_o.token_closed_here = 1'b1;
            mode_o = MODE_IDLE;
          end
        end
      end
      MODE_ESCAPE: begin
        if (is_nul) begin
          mark_o.stream_ended        = 1'b1;
          mark_o.unterminated_string = 1'b1;
          mode_o = MODE_IDLE;
        end else begin
          mark_o.byte_role  = ROLE_CONT;
          mark_o.token_kind = KIND_STRING;
          mode_o = MODE_STRING;
        end
      end
      MODE_ATOM: begin
        if (ends_atom) begin
          mark_o.atom_closed_before = 1'b1;
          mode_o = MODE_IDLE;
          fresh  = 1'b1;
        end else begin
          mark_o.byte_role  = ROLE_CONT;
          mark_o.token_kind = KIND_ATOM;
        end
      end
      default: begin
        mode_o = MODE_IDLE;
        fresh  = 1'b1;
      end
    endcase

    if (fresh) begin
      priority if (is_nul) begin
        mark_o.stream_ended = 1'b1;
      end else if (is_blank) begin
        mode_o = MODE_IDLE;
      end else if (byte_i == CHAR_SEMI) begin
        mode_o = MODE_COMMENT;
      end else if ((byte_i == CHAR_OPEN) || (byte_i == CHAR_CLOSE)) begin
        mark_o.byte_role         = ROLE_BEGIN;
        mark_o.token_kind        = (byte_i == CHAR_OPEN) ? KIND_OPEN : KIND_CLOSE;
        mark_o.token_closed_here = 1'b1;
      end else if (byte_i == CHAR_QUOTE) begin
        mark_o.byte_role  = ROLE_BEGIN;
        mark_o.token_kind = KIND_STRING;
        mode_o = MODE_STRING;
      end else begin
        mark_o.byte_role  = ROLE_BEGIN;
        mark_o.token_kind = KIND_ATOM;
        mode_o = MODE_ATOM;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/stbm_checker.sv @@
// Port-level checker for the token boundary marker and its bind.
`default_nettype none
`include "sexpr_token_boundary_marker_core_assert.svh"
module stbm_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [stbm_pkg::MarkW-1:0] m_axis_tdata
);
  import stbm_pkg::*;

  mark_t mark;
  logic  out_stall;
  logic  is_skip;
  logic  skip_ok;
  logic  unterm;
  logic  unterm_ok;
  logic  atom_end;
  logic  atom_ok;

  assign mark      = m_axis_tdata;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign is_skip   = m_axis_tvalid && (mark.byte_role == ROLE_SKIP);
  assign skip_ok   = (mark.token_kind == KIND_OPEN) && !mark.token_closed_here;
  assign unterm    = m_axis_tvalid && mark.unterminated_string;
  assign unterm_ok = mark.stream_ended && (mark.byte_role == ROLE_SKIP);
  assign atom_end  = m_axis_tvalid && mark.atom_closed_before;
  assign atom_ok   = (mark.byte_role != ROLE_CONT) && !mark.unterminated_string;

  `STBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `STBM_ASSERT_NOW(a_skip_no_kind, clk_i, rst_ni, is_skip, skip_ok)
  `STBM_ASSERT_NOW(a_unterm_ends, clk_i, rst_ni, unterm, unterm_ok)
  `STBM_ASSERT_NOW(a_atom_no_cont, clk_i, rst_ni, atom_end, atom_ok)

endmodule

bind sexpr_token_boundary_marker_core stbm_checker u_stbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ test/sexpr_token_boundary_marker_core_test.sv @@
// Self-checking stream testbench for the s-expression token boundary marker.
`timescale 1ns / 100ps
module sexpr_token_boundary_marker_core_test;
  import stbm_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned LongHold = 60;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  int unsigned cycles = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;

  sexpr_token_boundary_marker_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic bit is_blank(logic [7:0] b);
    return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic bit ends_atom(logic [7:0] b);
    return b == CHAR_NUL || is_blank(b) || b == CHAR_OPEN || b == CHAR_CLOSE ||
           b == CHAR_SEMI;
  endfunction

  class mark_scoreboard;
    mode_e       lex_mode;
    mark_t       pending_marks[$];
    int unsigned errors;
    int unsigned bytes_taken;
    int unsigned marks_checked;
    int unsigned streams_ended;
    int unsigned open_strings;

    function new();
      lex_mode = MODE_IDLE;
      errors = 0;
      bytes_taken = 0;
      marks_checked = 0;
      streams_ended = 0;
      open_strings = 0;
    endfunction

    function mark_t lex_byte(logic [7:0] b);
      mark_t m;
      mode_e nxt;
      bit    fresh;
      m = '0;
      nxt = lex_mode;
      fresh = 1'b0;
      case (lex_mode)
        MODE_COMMENT: begin
          if (b == CHAR_NUL) begin
            m.stream_ended = 1'b1;
            nxt = MODE_IDLE;
          end else if (b == CHAR_NEWLINE) begin
            nxt = MODE_IDLE;
          end
        end
        MODE_STRING, MODE_ESCAPE: begin
          if (b == CHAR_NUL) begin
            m.stream_ended = 1'b1;
            m.unterminated_string = 1'b1;
            nxt = MODE_IDLE;
          end else begin
            m.byte_role = ROLE_CONT;
            m.token_kind = KIND_STRING;
            if (lex_mode == MODE_ESCAPE) begin
              nxt = MODE_STRING;
            end else if (b == CHAR_BACKSLASH) begin
              nxt = MODE_ESCAPE;
            end else if (b == CHAR_QUOTE) begin
              m.token_closed_here = 1'b1;
              nxt = MODE_IDLE;
            end
          end
        end
        MODE_ATOM: begin
          if (ends_atom(b)) begin
            m.atom_closed_before = 1'b1;
            nxt = MODE_IDLE;
            fresh = 1'b1;
          end else begin
            m.byte_role = ROLE_CONT;
            m.token_kind = KIND_ATOM;
          end
        end
        default: begin
          nxt = MODE_IDLE;
          fresh = 1'b1;
        end
      endcase
      if (fresh) begin
        if (b == CHAR_NUL) begin
          m.stream_ended = 1'b1;
        end else if (is_blank(b)) begin
          nxt = MODE_IDLE;
        end else if (b == CHAR_SEMI) begin
          nxt = MODE_COMMENT;
        end else if (b == CHAR_OPEN || b == CHAR_CLOSE) begin
          m.byte_role = ROLE_BEGIN;
          m.token_kind = (b == CHAR_OPEN) ? KIND_OPEN : KIND_CLOSE;
          m.token_closed_here = 1'b1;
        end else if (b == CHAR_QUOTE) begin
          m.byte_role = ROLE_BEGIN;
          m.token_kind = KIND_STRING;
          nxt = MODE_STRING;
        end else begin
          m.byte_role = ROLE_BEGIN;
          m.token_kind = KIND_ATOM;
          nxt = MODE_ATOM;
        end
      end
      lex_mode = nxt;
      return m;
    endfunction

    function void note_byte(logic [7:0] b);
      bytes_taken++;
      pending_marks.push_back(lex_byte(b));
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH at word %0d, %s: got %0d, expected %0d",
               marks_checked, what, got, want);
      errors++;
    endtask

    task check_mark(logic [7:0] raw);
      mark_t got;
      mark_t want;
      got = mark_t'(raw);
      if (pending_marks.size() == 0) begin
        report("unexpected word", raw, 0);
        return;
      end
      want = pending_marks.pop_front();
      if (got.atom_closed_before != want.atom_closed_before)
        report("atom_closed_before", got.atom_closed_before, want.atom_closed_before);
      if (got.byte_role != want.byte_role)
        report("byte_role", got.byte_role, want.byte_role);
      if (got.token_kind != want.token_kind)
        report("token_kind", got.token_kind, want.token_kind);
      if (got.token_closed_here != want.token_closed_here)
        report("token_closed_here", got.token_closed_here, want.token_closed_here);
      if (got.stream_ended != want.stream_ended)
        report("stream_ended", got.stream_ended, want.stream_ended);
      if (got.unterminated_string != want.unterminated_string)
        report("unterminated_string", got.unterminated_string, want.unterminated_string);
      if (want.stream_ended) streams_ended++;
      if (want.unterminated_string) open_strings++;
      marks_checked++;
    endtask
  endclass

  mark_scoreboard sb = new();

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d words outstanding",
             cycles, sb.pending_marks.size());
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_mark(m_axis_tdata);
  end

  initial begin
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned style;
    hold_left = 0;
    phase_left = 0;
    style = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
        if (hold_left == 0) holds_done++;
      end else if (holds_done != holds_requested) begin
        m_axis_tready <= 1'b0;
        hold_left = LongHold;
      end else begin
        if (phase_left == 0) begin
          style = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 80);
        end
        phase_left--;
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= (phase_left % 8) < 3;
        endcase
      end
    end
  end

  task automatic drive_byte(logic [7:0] b);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic send_bytes(byte_q_t bytes, bit bursty);
    int unsigned burst_left;
    burst_left = 0;
    foreach (bytes[i]) begin
      if (bursty && burst_left == 0) begin
        idle_cycles($urandom_range(0, 6));
        burst_left = $urandom_range(1, 24);
      end
      drive_byte(bytes[i]);
      if (burst_left > 0) burst_left--;
    end
    idle_cycles(1);
  endtask

  task automatic wait_drained();
    while (sb.pending_marks.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] atom_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b = 8'(8'h61 + $urandom_range(0, 25));
      5, 6: b = 8'($urandom_range(128, 255));
      7: b = CHAR_QUOTE;
      default: begin
        do b = 8'($urandom_range(1, 255)); while (ends_atom(b));
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CHAR_NEWLINE);
    return b;
  endfunction

  function automatic void push_fragment(ref byte_q_t q);
    int unsigned n;
    logic [7:0]  blanks[6];
    blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, 8'h0B, 8'h0C, CHAR_CR};
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        n = $urandom_range(1, 8);
        repeat (n) q.push_back(atom_byte());
      end
      5, 6, 7: begin
        q.push_back(CHAR_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            q.push_back(CHAR_BACKSLASH);
            q.push_back(($urandom_range(0, 2) == 0) ? CHAR_QUOTE : text_byte());
          end else begin
            q.push_back(($urandom_range(0, 9) == 0) ? CHAR_NEWLINE : text_byte());
          end
        end
        if ($urandom_range(0, 9) != 0) q.push_back(CHAR_QUOTE);
      end
      8, 9: begin
        q.push_back(CHAR_SEMI);
        n = $urandom_range(0, 6);
        repeat (n) q.push_back(text_byte());
        q.push_back(($urandom_range(0, 7) == 0) ? CHAR_NUL : CHAR_NEWLINE);
      end
      10, 11, 12: q.push_back(blanks[$urandom_range(0, 5)]);
      13, 14, 15: q.push_back(($urandom_range(0, 1) == 0) ? CHAR_OPEN : CHAR_CLOSE);
      16: q.push_back(CHAR_NUL);
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  initial begin
    byte_q_t     directed;
    byte_q_t     chunk;
    int unsigned sent;
    directed = {CHAR_OPEN, 8'hFF, 8'h61, CHAR_TAB, CHAR_QUOTE, CHAR_BACKSLASH,
                CHAR_QUOTE, 8'h78, CHAR_QUOTE, CHAR_CLOSE, CHAR_SEMI, CHAR_OPEN,
                CHAR_NEWLINE, 8'h71, CHAR_QUOTE, 8'h72, CHAR_CR, CHAR_NUL,
                CHAR_QUOTE, CHAR_BACKSLASH, CHAR_NUL, CHAR_SEMI, CHAR_NUL,
                8'h80, CHAR_NUL};
    sent = directed.size();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_bytes(directed, 1'b0);
    wait_drained();

    chunk.delete();
    while (chunk.size() < 40) push_fragment(chunk);
    holds_requested++;
    send_bytes(chunk, 1'b0);
    sent += chunk.size();
    wait_drained();

    while (sent < RandomItems) begin
      chunk.delete();
      while (chunk.size() < 120 && sent + chunk.size() < RandomItems) push_fragment(chunk);
      send_bytes(chunk, $urandom_range(0, 3) != 0);
      sent += chunk.size();
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Lexed %0d bytes into %0d checked marks across bursty and back-to-back traffic.",
             sb.bytes_taken, sb.marks_checked);
    $display("Saw %0d end markers, %0d inside open strings, with long output stalls.",
             sb.streams_ended, sb.open_strings);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/stbm_pkg.sv
rtl/stbm_step.sv
rtl/sexpr_token_boundary_marker_core.sv
rtl/stbm_checker.sv
test/sexpr_token_boundary_marker_core_test.sv
